// ----- hdl/directory_record_parser_assert.svh -----
// assertion macros for the directory record parser
// needs clk_i and rst_ni in the scope of use
`ifndef DIRECTORY_RECORD_PARSER_ASSERT_SVH
`define DIRECTORY_RECORD_PARSER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DRP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("directory record parser: same-cycle check failed");

// next-cycle implication, disabled in reset
`define DRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("directory record parser: next-cycle check failed");

`endif

// ----- hdl/drp_pkg.sv -----
// shared types and constants of the directory record parser
// no dependencies
`timescale 1ns / 1ps

package drp_pkg;

  localparam int unsigned SECTOR_BYTES_DEF   = 2048;
  localparam int unsigned NAME_MAX_CHARS_DEF = 63;
  localparam int unsigned FIFO_DEPTH         = 4;

  localparam logic [31:0] DIR_BYTES_RESET   = 32'd2048;
  localparam logic [15:0] ENTRY_LIMIT_RESET = 16'd256;

  // record layout
  localparam logic [7:0] MIN_RECORD     = 8'd33;
  localparam logic [7:0] LBA_FIRST      = 8'd2;
  localparam logic [7:0] LBA_LAST       = 8'd5;
  localparam logic [7:0] SIZE_FIRST     = 8'd10;
  localparam logic [7:0] SIZE_LAST      = 8'd13;
  localparam logic [7:0] FLAGS_OFF      = 8'd25;
  localparam logic [7:0] NAME_LEN_OFF   = 8'd32;
  localparam int unsigned DIR_FLAG_BIT  = 1;
  localparam logic [7:0] BYTE_SEMICOLON = 8'h3B;
  localparam logic [7:0] BYTE_NUL       = 8'h00;
  localparam logic [7:0] BYTE_ONE       = 8'h01;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  typedef enum logic {
    REG_DIRECTORY_BYTES = 1'b0,
    REG_ENTRY_LIMIT     = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] directory_bytes;
    logic [15:0] entry_limit;
  } drp_cfg_t;

  // everything one byte produces, serialized later by the back end
  typedef struct packed {
    logic        has_char;
    logic        has_entry;
    logic        has_fin;
    logic [7:0]  name_char;
    logic [31:0] lba;
    logic [31:0] size;
    logic        is_dir;
    logic [5:0]  emitted;
    logic [15:0] index;
  } drp_bundle_t;

endpackage

// ----- hdl/drp_intf.sv -----
// channel interfaces of the directory record parser: input bytes,
// results and configuration writes; depends on drp_pkg
`timescale 1ns / 1ps

interface drp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  modport source (output valid, data_byte, first_byte, input ready);
  modport sink (input valid, data_byte, first_byte, output ready);
endinterface

interface drp_out_if import drp_pkg::*; ();
  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [7:0]  name_char;
  logic [31:0] entry_lba;
  logic [31:0] entry_size;
  logic        is_directory;
  logic [15:0] entry_index;
  logic [5:0]  name_length;
  logic        last_of_run;
  modport source (output valid, kind, name_char, entry_lba, entry_size, is_directory,
                  entry_index, name_length, last_of_run, input ready);
  modport sink (input valid, kind, name_char, entry_lba, entry_size, is_directory,
                entry_index, name_length, last_of_run, output ready);
endinterface

interface drp_cfg_if import drp_pkg::*; ();
  logic        valid;
  logic        ready;
  cfg_reg_e    index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/drp_fifo.sv -----
// result bundle queue between front and back end
// depends on drp_pkg
`timescale 1ns / 1ps

module drp_fifo import drp_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  drp_bundle_t wdata_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output drp_bundle_t rdata_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  drp_bundle_t      mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hdl/drp_front.sv -----
// front end: takes one byte per cycle while the queue has room, walks records and classifies results
// depends on drp_pkg and drp_intf
`timescale 1ns / 1ps

module drp_front import drp_pkg::*; #(
  parameter int unsigned SECTOR_BYTES   = SECTOR_BYTES_DEF,
  parameter int unsigned NAME_MAX_CHARS = NAME_MAX_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  drp_cfg_t    cfg_i,
  drp_in_if.sink      in_i,
  input  logic        full_i,
  output logic        push_o,
  output drp_bundle_t bundle_o
);

  localparam int unsigned SEC_W  = $clog2(SECTOR_BYTES);
  localparam int unsigned LEFT_W = $clog2(SECTOR_BYTES + 1);
  localparam logic [SEC_W-1:0]  SEC_LAST = SEC_W'(SECTOR_BYTES - 1);
  localparam logic [LEFT_W-1:0] SEC_SIZE = LEFT_W'(SECTOR_BYTES);
  localparam logic [8:0]        NAME_LIM = 9'(NAME_MAX_CHARS);

  logic [31:0]      dir_off_q, dir_off_d, dir_off_e;
  logic [SEC_W-1:0] sec_off_q, sec_off_d, sec_off_e;
  logic [7:0]       rec_off_q, rec_off_d, rec_off_e;
  logic [7:0]       rec_len_q, rec_len_d;
  logic [7:0]       name_bytes_q, name_bytes_d;
  logic [31:0]      lba_q, lba_d, size_q, size_d;
  logic             dir_flag_q, dir_flag_d;
  logic [5:0]       emitted_q, emitted_d;
  logic             cut_q, cut_d;
  logic             skip_q, skip_d, skip_e;
  logic [15:0]      entries_q, entries_d, entries_e;
  logic             finished_q, finished_d, finished_e;

  logic              fire, lt, active, abort, in_name;
  logic [31:0]       rem, left_wide;
  logic [LEFT_W-1:0] sec_room, left;
  logic [7:0]        b, idx, rec_len_m33;
  logic [1:0]        lane;
  logic              has_char, has_entry, has_fin;

  assign fire       = in_i.valid && in_i.ready;
  assign in_i.ready = !full_i;
  assign b          = in_i.data_byte;

  // a first byte restarts the walk before it is parsed
  always_comb begin
    dir_off_e  = in_i.first_byte ? '0 : dir_off_q;
    sec_off_e  = in_i.first_byte ? '0 : sec_off_q;
    rec_off_e  = in_i.first_byte ? '0 : rec_off_q;
    skip_e     = in_i.first_byte ? 1'b0 : skip_q;
    entries_e  = in_i.first_byte ? '0 : entries_q;
    finished_e = in_i.first_byte ? 1'b0 : finished_q;
  end

  // bytes left in this sector that still belong to the extent
  always_comb begin
    lt        = dir_off_e < cfg_i.directory_bytes;
    rem       = cfg_i.directory_bytes - dir_off_e;
    sec_room  = SEC_SIZE - {1'b0, sec_off_e};
    left_wide = (rem < 32'(sec_room)) ? rem : 32'(sec_room);
    left      = LEFT_W'(left_wide);
    active    = (entries_e < cfg_i.entry_limit) && lt;
  end

  always_comb begin
    dir_off_d    = dir_off_e;
    sec_off_d    = sec_off_e;
    rec_off_d    = rec_off_e;
    rec_len_d    = rec_len_q;
    name_bytes_d = name_bytes_q;
    lba_d        = lba_q;
    size_d       = size_q;
    dir_flag_d   = dir_flag_q;
    emitted_d    = emitted_q;
    cut_d        = cut_q;
    skip_d       = skip_e;
    entries_d    = entries_e;
    finished_d   = finished_e;
    has_char     = 1'b0;
    has_entry    = 1'b0;
    has_fin      = 1'b0;
    abort        = 1'b0;
    lane         = '0;
    rec_len_m33  = rec_len_q - MIN_RECORD;
    idx          = rec_off_e - MIN_RECORD;
    in_name      = 1'b0;

    if (!finished_e) begin
      if (active && !skip_e) begin
        if (rec_off_e == '0) begin
          // record start: short tail or bad length drops the sector
          if (left < LEFT_W'(MIN_RECORD) || b < MIN_RECORD || LEFT_W'(b) > left) begin
            skip_d = 1'b1;
          end else begin
            rec_len_d    = b;
            lba_d        = '0;
            size_d       = '0;
            dir_flag_d   = 1'b0;
            name_bytes_d = '0;
            emitted_d    = '0;
            cut_d        = 1'b0;
            rec_off_d    = 8'd1;
          end
        end else begin
          case (rec_off_e) inside
            [LBA_FIRST:LBA_LAST]: begin
              lane = 2'(rec_off_e - LBA_FIRST);
              lba_d[{lane, 3'b000} +: 8] = b;
            end
            [SIZE_FIRST:SIZE_LAST]: begin
              lane = 2'(rec_off_e - SIZE_FIRST);
              size_d[{lane, 3'b000} +: 8] = b;
            end
            FLAGS_OFF: begin
              dir_flag_d = b[DIR_FLAG_BIT];
            end
            NAME_LEN_OFF: begin
              if (b > rec_len_m33) begin
                skip_d = 1'b1;
                abort  = 1'b1;
              end else begin
                name_bytes_d = b;
              end
            end
            default: ;
          endcase

          if (!abort) begin
            // dot entries carry a single 0 or 1 byte as name
            in_name = (rec_off_e >= MIN_RECORD) &&
                      ({1'b0, rec_off_e} < {1'b0, MIN_RECORD} + {1'b0, name_bytes_q}) &&
                      !((rec_off_e == MIN_RECORD) && (name_bytes_q == BYTE_ONE) &&
                        (b <= BYTE_ONE));
            if (in_name) begin
              if (!cut_q && ({1'b0, idx} < NAME_LIM)) begin
                if (b == BYTE_SEMICOLON || b == BYTE_NUL) begin
                  cut_d = 1'b1;
                end else begin
                  emitted_d = emitted_q + 1'b1;
                  has_char  = 1'b1;
                end
              end
              if ({1'b0, rec_off_e} == {1'b0, NAME_LEN_OFF} + {1'b0, name_bytes_q}) begin
                has_entry = 1'b1;
                entries_d = entries_e + 1'b1;
              end
            end
            rec_off_d = ({1'b0, rec_off_e} + 9'd1 >= {1'b0, rec_len_q}) ? '0
                                                                        : rec_off_e + 1'b1;
          end
        end
      end

      if (lt) begin
        dir_off_d = dir_off_e + 1'b1;
      end
      if (sec_off_e == SEC_LAST) begin
        sec_off_d = '0;
        rec_off_d = '0;
        skip_d    = 1'b0;
      end else begin
        sec_off_d = sec_off_e + 1'b1;
      end

      if (!lt || rem == 32'd1 || entries_d >= cfg_i.entry_limit) begin
        finished_d = 1'b1;
        has_fin    = 1'b1;
      end
    end
  end

  always_comb begin
    bundle_o.has_char  = has_char;
    bundle_o.has_entry = has_entry;
    bundle_o.has_fin   = has_fin;
    bundle_o.name_char = b;
    bundle_o.lba       = lba_d;
    bundle_o.size      = size_d;
    bundle_o.is_dir    = dir_flag_d;
    bundle_o.emitted   = emitted_d;
    bundle_o.index     = entries_e;
  end

  assign push_o = fire && (has_char || has_entry || has_fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_off_q  <= '0;
      sec_off_q  <= '0;
      rec_off_q  <= '0;
      rec_len_q  <= '0;
      name_bytes_q <= '0;
      lba_q      <= '0;
      size_q     <= '0;
      dir_flag_q <= 1'b0;
      emitted_q  <= '0;
      cut_q      <= 1'b0;
      skip_q     <= 1'b0;
      entries_q  <= '0;
      finished_q <= 1'b1;
    end else if (fire) begin
      dir_off_q  <= dir_off_d;
      sec_off_q  <= sec_off_d;
      rec_off_q  <= rec_off_d;
      rec_len_q  <= rec_len_d;
      name_bytes_q <= name_bytes_d;
      lba_q      <= lba_d;
      size_q     <= size_d;
      dir_flag_q <= dir_flag_d;
      emitted_q  <= emitted_d;
      cut_q      <= cut_d;
      skip_q     <= skip_d;
      entries_q  <= entries_d;
      finished_q <= finished_d;
    end
  end

endmodule

// ----- hdl/drp_back.sv -----
// back end: turns each queued bundle into one to three result words
// depends on drp_pkg and drp_intf
`timescale 1ns / 1ps

module drp_back import drp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  drp_bundle_t rdata_i,
  output logic        pop_o,
  drp_out_if.source   out_o
);

  drp_bundle_t hold_q;
  logic [2:0]  pend_q, pend_d;   // {finish, entry, char} still to send
  logic [2:0]  low, rest, after;
  logic        fire;

  assign low   = pend_q & (~pend_q + 3'd1);
  assign rest  = pend_q & ~low;
  assign fire  = out_o.valid && out_o.ready;
  assign after = fire ? rest : pend_q;
  assign pop_o = (after == '0) && !empty_i;
  assign pend_d = pop_o ? {rdata_i.has_fin, rdata_i.has_entry, rdata_i.has_char} : after;

  always_comb begin
    out_o.valid        = (pend_q != '0);
    out_o.last_of_run  = (rest == '0);
    out_o.name_char    = '0;
    out_o.entry_lba    = hold_q.lba;
    out_o.entry_size   = hold_q.size;
    out_o.is_directory = hold_q.is_dir;
    out_o.entry_index  = hold_q.index;
    out_o.name_length  = hold_q.emitted;
    if (low[0]) begin
      out_o.kind      = KIND_CHAR;
      out_o.name_char = hold_q.name_char;
    end else if (low[1]) begin
      out_o.kind = KIND_ENTRY;
    end else begin
      out_o.kind         = KIND_FINISH;
      out_o.entry_lba    = '0;
      out_o.entry_size   = '0;
      out_o.is_directory = 1'b0;
      out_o.name_length  = '0;
      out_o.entry_index  = hold_q.index + {15'd0, hold_q.has_entry};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hold_q <= rdata_i;
    end
  end

endmodule

// ----- hdl/directory_record_parser.sv -----
// directory record parser top level: one extent byte accepted per cycle
// while the queue has room, its results queued and then held in the back end.
// results leave one word per cycle while ready is high; a byte makes at most
// three, and a four-bundle queue lets bytes keep coming while the output drains.
// reset (async, active low) clears positions and count and leaves the block
// finished, so bytes are dropped until one arrives with first_byte set.
`timescale 1ns / 1ps
`include "directory_record_parser_assert.svh"

module directory_record_parser import drp_pkg::*; #(
  parameter int unsigned SECTOR_BYTES   = SECTOR_BYTES_DEF,
  parameter int unsigned NAME_MAX_CHARS = NAME_MAX_CHARS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  drp_cfg_if.sink   cfg_i,
  drp_in_if.sink    in_i,
  drp_out_if.source out_o
);

  drp_cfg_t    cfg_q;
  drp_bundle_t push_bundle, pop_bundle;
  logic        push, pop, full, empty;

  // configuration registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.directory_bytes <= DIR_BYTES_RESET;
      cfg_q.entry_limit     <= ENTRY_LIMIT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DIRECTORY_BYTES: cfg_q.directory_bytes <= cfg_i.data;
        REG_ENTRY_LIMIT:     cfg_q.entry_limit     <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // front: record walk, one byte per cycle while the queue has room
  drp_front #(
    .SECTOR_BYTES   (SECTOR_BYTES),
    .NAME_MAX_CHARS (NAME_MAX_CHARS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_i),
    .full_i   (full),
    .push_o   (push),
    .bundle_o (push_bundle)
  );

  // queue of per-byte result bundles
  drp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_bundle),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (pop_bundle)
  );

  // back: char, entry and finish words in that order
  drp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .rdata_i (pop_bundle),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // the front never writes into a full queue
  `DRP_ASSERT_NOW(a_no_push_full, push, !full)
  // the back only takes a bundle that is there
  `DRP_ASSERT_NOW(a_no_pop_empty, pop, !empty)
  // a finish word always closes its byte's run
  `DRP_ASSERT_NOW(a_finish_last, out_o.valid && (out_o.kind == KIND_FINISH), out_o.last_of_run)
  // last word taken with nothing queued leaves the output empty
  `DRP_ASSERT_NEXT(a_drain_idle, out_o.valid && out_o.ready && out_o.last_of_run && empty,
                   !out_o.valid)

endmodule
